### hdl/sbcd_pkg.sv
// Package for the signed BCD add/subtract/multiply unit.
// Holds the operand size, request codes, sequencer states and digit-unit opcodes.
// No dependencies.
`timescale 1ns / 1ps

package sbcd_pkg;

    localparam int NUM_DIGITS = 16;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    typedef logic [3:0] t_digit;
    typedef logic [DIG_IDX_W-1:0] t_dig_idx;

    typedef enum logic [2:0] {
        REQ_LOAD  = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_SUB   = 3'd2,
        REQ_MUL   = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADDSUB,
        ST_MUL,
        ST_COPY,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC
    } t_alu_op;

endpackage

### hdl/sbcd_digit_alu.sv
// Shared single-digit decimal arithmetic unit: add with carry, subtract with borrow,
// and multiply-accumulate with a carry digit. Depends on sbcd_pkg.
`timescale 1ns / 1ps

module sbcd_digit_alu (
    input  sbcd_pkg::t_alu_op i_op,
    input  sbcd_pkg::t_digit  i_x,
    input  sbcd_pkg::t_digit  i_y,
    input  sbcd_pkg::t_digit  i_m,
    input  sbcd_pkg::t_digit  i_cin,
    output sbcd_pkg::t_digit  o_digit,
    output sbcd_pkg::t_digit  o_cout
);
    import sbcd_pkg::*;

    logic [4:0]  sum;
    logic [4:0]  sub;
    logic [4:0]  diff;
    logic [7:0]  mul;
    logic [7:0]  acc;
    logic [15:0] recip;
    logic [3:0]  quo;
    logic [7:0]  rem;

    always_comb begin
        sum   = {1'b0, i_x} + {1'b0, i_y} + {1'b0, i_cin};
        sub   = {1'b0, i_y} + {1'b0, i_cin};
        diff  = {1'b0, i_x} + 5'd10 - sub;
        mul   = {4'b0, i_x} * {4'b0, i_m};
        acc   = mul + {4'b0, i_y} + {4'b0, i_cin};
        // Division by ten of a value below 100 via multiply by 205 and shift by 11.
        recip = {8'b0, acc} * 16'd205;
        quo   = recip[14:11];
        rem   = acc - ({4'b0, quo} * 8'd10);
        case (i_op)
            ALU_ADD: begin
                if (sum >= 5'd10) begin
                    o_digit = 4'(sum - 5'd10);
                    o_cout  = 4'd1;
                end else begin
                    o_digit = sum[3:0];
                    o_cout  = 4'd0;
                end
            end
            ALU_SUB: begin
                if ({1'b0, i_x} < sub) begin
                    o_digit = diff[3:0];
                    o_cout  = 4'd1;
                end else begin
                    o_digit = 4'({1'b0, i_x} - sub);
                    o_cout  = 4'd0;
                end
            end
            ALU_MAC: begin
                o_digit = rem[3:0];
                o_cout  = quo;
            end
            default: begin
                o_digit = 4'd0;
                o_cout  = 4'd0;
            end
        endcase
    end

endmodule

### hdl/signed_bcd_add_sub_mul_unit.sv
// Signed BCD add/subtract/multiply unit: operand registers, sequencer and output register;
// depends on sbcd_pkg and sbcd_digit_alu. Loads, clears and unused codes complete in idle.
// An add of like signs or a subtract of unlike signs walks the 16 digits once; otherwise a
// compare pass comes first. Multiply forms the 256 digit products in turn, then copies
// the product. Digits go out one per cycle unless the output stalls; input is ready again
// once the last digit is loaded. Sync active-low reset clears all but the output payload.
`timescale 1ns / 1ps

module signed_bcd_add_sub_mul_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_req_type,
    input  logic       i_load_b,
    input  logic [3:0] i_digit_pos,
    input  logic [3:0] i_digit_value,
    input  logic       i_a_negative,
    input  logic       i_b_negative,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_result_digit,
    output logic [3:0] o_result_pos,
    output logic       o_result_negative,
    output logic       o_overflow_error,
    output logic       o_last_digit
);
    import sbcd_pkg::*;

    t_state   r_state, n_state;
    t_digit   r_a [NUM_DIGITS];
    t_digit   r_b [NUM_DIGITS];
    t_digit   r_p [NUM_DIGITS];
    t_dig_idx r_i, r_j, r_top;
    t_digit   r_carry;
    logic     r_nz, r_ovf, r_sub, r_swap, r_a_ge, r_neg, r_eff_b;

    logic     r_out_valid;
    t_digit   r_out_digit;
    t_dig_idx r_out_pos;
    logic     r_out_neg, r_out_ovf, r_out_last;

    logic       in_fire, out_load, last_i, last_j, eff_b, same_sign, cmp_ge;
    logic [DIG_IDX_W:0] mul_pos;
    t_digit     load_val;
    t_alu_op    alu_op;
    t_digit     alu_x, alu_y, alu_m, alu_digit, alu_cout;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign last_i     = (r_i == t_dig_idx'(NUM_DIGITS - 1));
    assign last_j     = (r_j == t_dig_idx'(NUM_DIGITS - 1));
    assign eff_b      = (i_req_type == REQ_SUB) ? !i_b_negative : i_b_negative;
    assign same_sign  = (i_a_negative == eff_b);
    assign mul_pos    = {1'b0, r_i} + {1'b0, r_j};
    assign load_val   = (i_digit_value > 4'd9) ? 4'd9 : i_digit_value;

    // Magnitude compare walks upward; a higher differing digit overrides lower ones.
    always_comb begin
        if (r_a[r_j] > r_b[r_j]) begin
            cmp_ge = 1'b1;
        end else if (r_a[r_j] < r_b[r_j]) begin
            cmp_ge = 1'b0;
        end else begin
            cmp_ge = r_a_ge;
        end
    end

    always_comb begin
        alu_op = ALU_ADD;
        alu_x  = r_a[r_j];
        alu_y  = r_b[r_j];
        alu_m  = r_b[r_i];
        if (r_state == ST_MUL) begin
            alu_op = ALU_MAC;
            alu_y  = mul_pos[DIG_IDX_W] ? 4'd0 : r_p[mul_pos[DIG_IDX_W-1:0]];
        end else begin
            alu_op = r_sub ? ALU_SUB : ALU_ADD;
            if (r_swap) begin
                alu_x = r_b[r_j];
                alu_y = r_a[r_j];
            end
        end
    end

    sbcd_digit_alu u_alu (
        .i_op    (alu_op),
        .i_x     (alu_x),
        .i_y     (alu_y),
        .i_m     (alu_m),
        .i_cin   (r_carry),
        .o_digit (alu_digit),
        .o_cout  (alu_cout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_req_type) inside
                        REQ_ADD, REQ_SUB: n_state = same_sign ? ST_ADDSUB : ST_CMP;
                        REQ_MUL:          n_state = ST_MUL;
                        default:          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CMP:    if (last_j) n_state = ST_ADDSUB;
            ST_ADDSUB: if (last_j) n_state = ST_EMIT;
            ST_MUL:    if (last_j && last_i) n_state = ST_COPY;
            ST_COPY:   if (last_j) n_state = ST_EMIT;
            ST_EMIT:   if (out_load && r_j == r_top) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '{default: '0};
            r_b         <= '{default: '0};
            r_p         <= '{default: '0};
            r_i         <= '0;
            r_j         <= '0;
            r_top       <= '0;
            r_carry     <= '0;
            r_nz        <= 1'b0;
            r_ovf       <= 1'b0;
            r_sub       <= 1'b0;
            r_swap      <= 1'b0;
            r_a_ge      <= 1'b1;
            r_neg       <= 1'b0;
            r_eff_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (i_req_type) inside
                            REQ_LOAD: begin
                                if (i_load_b) begin
                                    r_b[i_digit_pos] <= load_val;
                                end else begin
                                    r_a[i_digit_pos] <= load_val;
                                end
                            end
                            REQ_CLEAR: begin
                                r_a <= '{default: '0};
                                r_b <= '{default: '0};
                            end
                            REQ_ADD, REQ_SUB, REQ_MUL: begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_carry <= '0;
                                r_top   <= '0;
                                r_nz    <= 1'b0;
                                r_ovf   <= 1'b0;
                                r_sub   <= !same_sign;
                                r_swap  <= 1'b0;
                                r_a_ge  <= 1'b1;
                                r_eff_b <= eff_b;
                                if (i_req_type == REQ_MUL) begin
                                    r_p   <= '{default: '0};
                                    r_neg <= i_a_negative ^ i_b_negative;
                                end else begin
                                    r_neg <= i_a_negative;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_CMP: begin
                    r_a_ge <= cmp_ge;
                    r_j    <= r_j + 1'b1;
                    if (last_j) begin
                        // Subtract the smaller magnitude from the larger one.
                        r_swap <= !cmp_ge;
                        r_neg  <= cmp_ge ? r_neg : r_eff_b;
                    end
                end
                ST_ADDSUB: begin
                    r_a[r_j] <= alu_digit;
                    r_carry  <= alu_cout;
                    r_j      <= r_j + 1'b1;
                    if (alu_digit != 4'd0) begin
                        r_top <= r_j;
                        r_nz  <= 1'b1;
                    end
                    if (last_j) begin
                        r_b <= '{default: '0};
                        if (!r_sub && alu_cout != 4'd0) begin
                            r_a   <= '{default: '0};
                            r_ovf <= 1'b1;
                            r_top <= '0;
                            r_nz  <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    if (!mul_pos[DIG_IDX_W]) begin
                        r_p[mul_pos[DIG_IDX_W-1:0]] <= alu_digit;
                    end else if (alu_digit != 4'd0) begin
                        r_ovf <= 1'b1;
                    end
                    r_carry <= alu_cout;
                    r_j     <= r_j + 1'b1;
                    if (last_j) begin
                        r_carry <= '0;
                        r_i     <= r_i + 1'b1;
                        if (alu_cout != 4'd0) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_COPY: begin
                    r_a[r_j] <= r_p[r_j];
                    r_j      <= r_j + 1'b1;
                    if (r_p[r_j] != 4'd0) begin
                        r_top <= r_j;
                        r_nz  <= 1'b1;
                    end
                    if (last_j) begin
                        r_b <= '{default: '0};
                        if (r_ovf) begin
                            r_a   <= '{default: '0};
                            r_top <= '0;
                            r_nz  <= 1'b0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_j         <= r_j + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output payload; a zero result always carries the plus sign.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_digit <= r_a[r_j];
            r_out_pos   <= r_j;
            r_out_neg   <= r_neg && r_nz;
            r_out_ovf   <= r_ovf;
            r_out_last  <= (r_j == r_top);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_digit    = r_out_digit;
    assign o_result_pos      = r_out_pos;
    assign o_result_negative = r_out_neg;
    assign o_overflow_error  = r_out_ovf;
    assign o_last_digit      = r_out_last;

endmodule
